[rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared codes, sizes and the result record of the clipped primitive
// rasterizer.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int SIZE_W  = 13;
	localparam int PIX_W   = 12;
	localparam int COLOR_W = 24;
	localparam int FB_MAX  = 4096;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_POINT = 2'd1,
		OP_FILL  = 2'd2,
		OP_LINE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RECT = 2'd1,
		MODE_LINE = 2'd2
	} mode_t;

	typedef enum logic {
		REG_FB_WIDTH  = 1'b0,
		REG_FB_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               pixel_valid;
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last;
		logic               busy_res;
		logic               rejected;
	} res_t;

endpackage

[rtl/cpr_walk.sv]
// ----------------------------------------------------------------------------
// cpr_walk
// Command setup, clipping and one walk step per item; holds the walk state.
// ----------------------------------------------------------------------------
module cpr_walk import cpr_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  cmd_t                 command,
	input  logic signed [CW-1:0] a_x,
	input  logic signed [CW-1:0] a_y,
	input  logic signed [CW-1:0] b_x,
	input  logic signed [CW-1:0] b_y,
	input  logic [COLOR_W-1:0]   color,
	input  logic [SIZE_W-1:0]    eff_w,
	input  logic [SIZE_W-1:0]    eff_h,
	output res_t                 res
);

	localparam int PW = ((CW > SIZE_W) ? CW : SIZE_W) + 2;
	localparam int DW = CW + 1;
	localparam int EW = CW + 2;
	localparam logic signed [PW-1:0] P_ONE = PW'(1);

	mode_t                  mode_q, mode_e, mode_n;
	logic signed [PW-1:0]   cur_x_q, cur_y_q, end_x_q, end_y_q, row_start_q;
	logic signed [PW-1:0]   cur_x_e, cur_y_e, end_x_e, end_y_e, row_start_e;
	logic signed [PW-1:0]   cur_x_n, cur_y_n;
	logic signed [EW-1:0]   err_q, err_e, err_n;
	logic signed [DW-1:0]   dx_q, dy_q, dx_e, dy_e;
	logic [1:0]             signs_q, signs_e;
	logic [COLOR_W-1:0]     held_q, color_e;

	logic signed [PW-1:0]   ax_p, ay_p, bx_p, by_p, w_p, h_p;
	logic signed [PW-1:0]   rx_raw, ry_raw, rx_start, ry_start, rx_end, ry_end;
	logic                   rect_empty, line_same, idle, start_rect, start_line;
	logic signed [DW-1:0]   ddx, ddy, adx, ady;
	logic signed [EW-1:0]   l_err;

	logic signed [PW-1:0]   ry_inc, rx_inc, lx_n, ly_n, px, py;
	logic                   r_col, r_row, stx, sty, l_done, on_fb, draw;
	logic signed [EW:0]     e2, dx_w, dy_w;
	logic signed [EW-1:0]   dx_ew, dy_ew;

	// sign-extend coordinates and zero-extend sizes to the position width
	assign ax_p = {{(PW-CW){a_x[CW-1]}}, a_x};
	assign ay_p = {{(PW-CW){a_y[CW-1]}}, a_y};
	assign bx_p = {{(PW-CW){b_x[CW-1]}}, b_x};
	assign by_p = {{(PW-CW){b_y[CW-1]}}, b_y};
	assign w_p  = {{(PW-SIZE_W){1'b0}}, eff_w};
	assign h_p  = {{(PW-SIZE_W){1'b0}}, eff_h};

	// rectangle clip: exclusive end bounds
	always_comb begin
		rx_raw   = ax_p + bx_p;
		ry_raw   = ay_p + by_p;
		rx_start = ax_p[PW-1] ? '0 : ax_p;
		ry_start = ay_p[PW-1] ? '0 : ay_p;
		rx_end   = (rx_raw > w_p) ? w_p : rx_raw;
		ry_end   = (ry_raw > h_p) ? h_p : ry_raw;
		rect_empty = rx_raw[PW-1] || (rx_raw == '0) || ry_raw[PW-1] || (ry_raw == '0) ||
			(ax_p >= w_p) || (ay_p >= h_p) || (rx_end <= rx_start) || (ry_end <= ry_start);
	end

	// line setup
	always_comb begin
		ddx = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
		ddy = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
		adx = ddx[DW-1] ? -ddx : ddx;
		ady = ddy[DW-1] ? -ddy : ddy;
		l_err = {adx[DW-1], adx} - {ady[DW-1], ady};
		line_same = (a_x == b_x) && (a_y == b_y);
	end

	assign idle       = (mode_q == MODE_IDLE);
	assign start_rect = idle && (command == OP_FILL) && !rect_empty;
	assign start_line = idle && (command == OP_LINE) && !line_same;

	// state seen by the step: freshly loaded walk or the running one
	always_comb begin
		mode_e      = mode_q;
		cur_x_e     = cur_x_q;
		cur_y_e     = cur_y_q;
		end_x_e     = end_x_q;
		end_y_e     = end_y_q;
		row_start_e = row_start_q;
		err_e       = err_q;
		dx_e        = dx_q;
		dy_e        = dy_q;
		signs_e     = signs_q;
		color_e     = (idle && (command != OP_TICK)) ? color : held_q;
		if (start_rect) begin
			mode_e      = MODE_RECT;
			cur_x_e     = rx_start;
			cur_y_e     = ry_start;
			row_start_e = ry_start;
			end_x_e     = rx_end;
			end_y_e     = ry_end;
		end else if (start_line) begin
			mode_e  = MODE_LINE;
			cur_x_e = ax_p;
			cur_y_e = ay_p;
			end_x_e = bx_p;
			end_y_e = by_p;
			err_e   = l_err;
			dx_e    = adx;
			dy_e    = -ady;
			signs_e = {!(a_y < b_y), !(a_x < b_x)};
		end
	end

	// step datapath shared by next state and result
	always_comb begin
		ry_inc = cur_y_e + P_ONE;
		rx_inc = cur_x_e + P_ONE;
		r_col  = ry_inc < end_y_e;
		r_row  = rx_inc < end_x_e;
		dx_ew  = {dx_e[DW-1], dx_e};
		dy_ew  = {dy_e[DW-1], dy_e};
		dx_w   = {dx_ew[EW-1], dx_ew};
		dy_w   = {dy_ew[EW-1], dy_ew};
		e2     = {err_e, 1'b0};
		stx    = e2 >= dy_w;
		sty    = e2 <= dx_w;
		err_n  = err_e + (stx ? dy_ew : '0) + (sty ? dx_ew : '0);
		lx_n   = cur_x_e;
		ly_n   = cur_y_e;
		if (stx)
			lx_n = signs_e[0] ? (cur_x_e - P_ONE) : (cur_x_e + P_ONE);
		if (sty)
			ly_n = signs_e[1] ? (cur_y_e - P_ONE) : (cur_y_e + P_ONE);
		l_done = (lx_n == end_x_e) && (ly_n == end_y_e);
	end

	// next state
	always_comb begin
		mode_n  = mode_e;
		cur_x_n = cur_x_e;
		cur_y_n = cur_y_e;
		case (mode_e)
			MODE_RECT: begin
				if (r_col) begin
					cur_y_n = ry_inc;
				end else if (r_row) begin
					cur_x_n = rx_inc;
					cur_y_n = row_start_e;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
			MODE_LINE: begin
				cur_x_n = lx_n;
				cur_y_n = ly_n;
				if (l_done)
					mode_n = MODE_IDLE;
			end
			default: mode_n = MODE_IDLE;
		endcase
	end

	// result
	always_comb begin
		px   = ax_p;
		py   = ay_p;
		draw = idle && (command == OP_POINT);
		res  = '0;
		case (mode_e)
			MODE_RECT: begin
				px       = cur_x_e;
				py       = cur_y_e;
				draw     = 1'b1;
				res.last = !r_col && !r_row;
			end
			MODE_LINE: begin
				px       = lx_n;
				py       = ly_n;
				draw     = 1'b1;
				res.last = l_done;
			end
			default: res.last = idle && (command != OP_TICK);
		endcase
		on_fb = !px[PW-1] && !py[PW-1] && (px < w_p) && (py < h_p);
		if (draw && on_fb) begin
			res.pixel_valid = 1'b1;
			res.pixel_x     = px[PIX_W-1:0];
			res.pixel_y     = py[PIX_W-1:0];
			res.pixel_color = color_e;
		end
		res.busy_res = (mode_n != MODE_IDLE);
		res.rejected = !idle && (command != OP_TICK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (step_en) begin
			mode_q <= mode_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			cur_x_q     <= cur_x_n;
			cur_y_q     <= cur_y_n;
			end_x_q     <= end_x_e;
			end_y_q     <= end_y_e;
			row_start_q <= row_start_e;
			err_q       <= (mode_e == MODE_LINE) ? err_n : err_e;
			dx_q        <= dx_e;
			dy_q        <= dy_e;
			signs_q     <= signs_e;
			held_q      <= color_e;
		end
	end

endmodule

[rtl/clipped_primitive_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// clipped_primitive_rasterizer_top
// Point, clipped rectangle fill and Bresenham line rasterizer, one pixel
// write result per command beat.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  command   cmd_valid / cmd_stall   command, a_x, a_y, b_x, b_y, color
//  result    res_valid / res_stall   pixel_valid, pixel_x, pixel_y, pixel_color,
//                                    last, busy_res, rejected
//  config    cfg_we                  cfg_index, cfg_wdata
//
// One beat per cycle sustained while the result is not stalled. An accepted
// beat is held in the input register until it fires; firing loads its result
// into the result register, which holds it on the result port.
// The per-beat walk step (clip compare, Bresenham error add) sits between
// the input register and the result register.
// Reset clears the walk mode, the handshake valids and loads the framebuffer
// size to 640 x 480.
// A stalled result holds in its register; the input register still takes one
// more beat, then cmd_stall rises until the result drains.
//
module clipped_primitive_rasterizer_top import cpr_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [SIZE_W-1:0]             cfg_wdata,
	// command channel
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [1:0]                    command,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic [COLOR_W-1:0]            color,
	// result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          pixel_valid,
	output logic [PIX_W-1:0]              pixel_x,
	output logic [PIX_W-1:0]              pixel_y,
	output logic [COLOR_W-1:0]            pixel_color,
	output logic                          last,
	output logic                          busy_res,
	output logic                          rejected
);

	logic [SIZE_W-1:0]             fb_width_q, fb_height_q, eff_w, eff_h;

	logic                          valid_s1;
	logic [1:0]                    command_s1;
	logic signed [COORD_WIDTH-1:0] a_x_s1, a_y_s1, b_x_s1, b_y_s1;
	logic [COLOR_W-1:0]            color_s1;

	logic                          fire;
	res_t                          res_c, res_q;
	logic                          res_valid_q;

	// configuration registers; sizes above the framebuffer limit clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q  <= SIZE_W'(640);
			fb_height_q <= SIZE_W'(480);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FB_WIDTH:  fb_width_q  <= cfg_wdata;
				REG_FB_HEIGHT: fb_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign eff_w = (fb_width_q  > SIZE_W'(FB_MAX)) ? SIZE_W'(FB_MAX) : fb_width_q;
	assign eff_h = (fb_height_q > SIZE_W'(FB_MAX)) ? SIZE_W'(FB_MAX) : fb_height_q;

	// advance the held beat whenever the result register is free or draining
	assign fire      = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			command_s1 <= command;
			a_x_s1     <= a_x;
			a_y_s1     <= a_y;
			b_x_s1     <= b_x;
			b_y_s1     <= b_y;
			color_s1   <= color;
		end
	end

	cpr_walk #(
		.CW (COORD_WIDTH)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (fire),
		.command (cmd_t'(command_s1)),
		.a_x     (a_x_s1),
		.a_y     (a_y_s1),
		.b_x     (b_x_s1),
		.b_y     (b_y_s1),
		.color   (color_s1),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.res     (res_c)
	);

	// result register: load on fire, drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_c;
	end

	assign res_valid   = res_valid_q;
	assign pixel_valid = res_q.pixel_valid;
	assign pixel_x     = res_q.pixel_x;
	assign pixel_y     = res_q.pixel_y;
	assign pixel_color = res_q.pixel_color;
	assign last        = res_q.last;
	assign busy_res    = res_q.busy_res;
	assign rejected    = res_q.rejected;

	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1)
		else $error("command stalled with no beat held");

	a_fire_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_q)
		else $error("fired beat did not reach the result register");

	a_held_beat_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(command_s1) && $stable(a_x_s1)))
		else $error("held input beat changed while blocked");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.last) |-> !res_q.busy_res)
		else $error("final step reported with walk still running");

	a_no_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.pixel_valid) |->
			(res_q.pixel_x == '0 && res_q.pixel_y == '0 && res_q.pixel_color == '0))
		else $error("pixel fields set without a pixel write");

endmodule

[tb/sv/cpr_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_result_checker
// Watches the configuration, command and result ports of the rasterizer. It
// keeps its own walk state and framebuffer size, works out the result of
// every accepted command beat and compares each result beat, field by field,
// with the oldest result still due.
// ----------------------------------------------------------------------------
module cpr_result_checker import cpr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [SIZE_W-1:0]        cfg_wdata,
	input  logic                     cmd_valid,
	input  logic                     cmd_stall,
	input  logic [1:0]               command,
	input  logic signed [15:0]       a_x,
	input  logic signed [15:0]       a_y,
	input  logic signed [15:0]       b_x,
	input  logic signed [15:0]       b_y,
	input  logic [COLOR_W-1:0]       color,
	input  logic                     res_valid,
	input  logic                     res_stall,
	input  logic                     pixel_valid,
	input  logic [PIX_W-1:0]         pixel_x,
	input  logic [PIX_W-1:0]         pixel_y,
	input  logic [COLOR_W-1:0]       pixel_color,
	input  logic                     last,
	input  logic                     busy_res,
	input  logic                     rejected,
	output int                       pending,
	output int                       mismatches,
	output int                       pixel_count,
	output int                       reject_count
);

	logic [SIZE_W-1:0]  fb_w;
	logic [SIZE_W-1:0]  fb_h;
	mode_t              walk;
	logic signed [15:0] cur_x;
	logic signed [15:0] cur_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic signed [15:0] row_start;
	logic signed [17:0] err;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [1:0]         signs;
	logic [COLOR_W-1:0] pen;
	res_t               due_results[$];
	int                 bad;

	function automatic int clip_size(logic [SIZE_W-1:0] v);
		return (v > FB_MAX) ? FB_MAX : int'(v);
	endfunction

	function automatic string show(res_t r);
		return $sformatf("pix=%0b x=%0d y=%0d color=%06h last=%0b busy=%0b rej=%0b",
			r.pixel_valid, r.pixel_x, r.pixel_y, r.pixel_color, r.last, r.busy_res,
			r.rejected);
	endfunction

	// write a pixel only if it lands on the current framebuffer
	function automatic void plot(input int x, input int y, inout res_t r);
		if (x >= 0 && y >= 0 && x < clip_size(fb_w) && y < clip_size(fb_h)) begin
			r.pixel_valid = 1'b1;
			r.pixel_x     = x[PIX_W-1:0];
			r.pixel_y     = y[PIX_W-1:0];
			r.pixel_color = pen;
		end
	endfunction

	task automatic walk_step(inout res_t r);
		logic signed [18:0] e2;
		case (walk)
			MODE_RECT: begin
				plot(int'(cur_x), int'(cur_y), r);
				if (int'(cur_y) + 1 < int'(end_y)) begin
					cur_y = cur_y + 16'sd1;
				end else if (int'(cur_x) + 1 < int'(end_x)) begin
					cur_x = cur_x + 16'sd1;
					cur_y = row_start;
				end else begin
					walk   = MODE_IDLE;
					r.last = 1'b1;
				end
			end
			MODE_LINE: begin
				e2 = {err, 1'b0};
				if (e2 >= dy) begin
					err   = err + dy;
					cur_x = cur_x + (signs[0] ? -16'sd1 : 16'sd1);
				end
				if (e2 <= dx) begin
					err   = err + dx;
					cur_y = cur_y + (signs[1] ? -16'sd1 : 16'sd1);
				end
				plot(int'(cur_x), int'(cur_y), r);
				if (cur_x == end_x && cur_y == end_y) begin
					walk   = MODE_IDLE;
					r.last = 1'b1;
				end
			end
			default: begin
				walk = MODE_IDLE;
			end
		endcase
	endtask

	task automatic rasterize_beat(input cmd_t c, input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] bx,
			input logic signed [15:0] by, input logic [COLOR_W-1:0] col,
			output res_t r);
		int x, y, w, h, ix, iy, jx, jy, adx, ady, e;
		r  = '0;
		ix = int'(ax);
		iy = int'(ay);
		jx = int'(bx);
		jy = int'(by);
		if (walk != MODE_IDLE) begin
			// a draw arriving mid-walk bounces, but the walk still steps
			r.rejected = (c != OP_TICK);
			walk_step(r);
		end else begin
			case (c)
				OP_POINT: begin
					pen = col;
					plot(ix, iy, r);
					r.last = 1'b1;
				end
				OP_FILL: begin
					pen = col;
					x   = ix;
					y   = iy;
					w   = jx;
					h   = jy;
					if (x + w <= 0 || y + h <= 0 || x >= clip_size(fb_w) ||
							y >= clip_size(fb_h)) begin
						r.last = 1'b1;
					end else begin
						if (x < 0) begin
							w = x + w;
							x = 0;
						end
						if (y < 0) begin
							h = y + h;
							y = 0;
						end
						if (x + w >= clip_size(fb_w)) w = clip_size(fb_w) - x;
						if (y + h >= clip_size(fb_h)) h = clip_size(fb_h) - y;
						if (w <= 0 || h <= 0) begin
							r.last = 1'b1;
						end else begin
							e         = x + w;
							cur_x     = x[15:0];
							cur_y     = y[15:0];
							row_start = y[15:0];
							end_x     = e[15:0];
							e         = y + h;
							end_y     = e[15:0];
							walk      = MODE_RECT;
							walk_step(r);
						end
					end
				end
				OP_LINE: begin
					pen = col;
					if (ix == jx && iy == jy) begin
						r.last = 1'b1;
					end else begin
						adx   = (jx > ix) ? jx - ix : ix - jx;
						ady   = (jy > iy) ? jy - iy : iy - jy;
						e     = adx - ady;
						ady   = -ady;
						dx    = adx[16:0];
						dy    = ady[16:0];
						err   = e[17:0];
						signs = {iy >= jy, ix >= jx};
						cur_x = ax;
						cur_y = ay;
						end_x = bx;
						end_y = by;
						walk  = MODE_LINE;
						walk_step(r);
					end
				end
				default: begin
				end
			endcase
		end
		r.busy_res = (walk != MODE_IDLE);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		res_t got;
		if (!arst_n) begin
			fb_w      = 13'd640;
			fb_h      = 13'd480;
			walk      = MODE_IDLE;
			cur_x     = '0;
			cur_y     = '0;
			end_x     = '0;
			end_y     = '0;
			row_start = '0;
			err       = '0;
			dx        = '0;
			dy        = '0;
			signs     = '0;
			pen       = '0;
			bad       = 0;
			due_results.delete();
			pending      <= 0;
			mismatches   <= 0;
			pixel_count  <= 0;
			reject_count <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				got = {pixel_valid, pixel_x, pixel_y, pixel_color, last, busy_res, rejected};
				pixel_count  <= pixel_count + (got.pixel_valid === 1'b1);
				reject_count <= reject_count + (got.rejected === 1'b1);
				if (due_results.size() == 0) begin
					bad++;
					if (bad <= 10) $display("result beat with nothing due: %s", show(got));
				end else begin
					want = due_results.pop_front();
					if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
							got.pixel_y !== want.pixel_y ||
							got.pixel_color !== want.pixel_color || got.last !== want.last ||
							got.busy_res !== want.busy_res ||
							got.rejected !== want.rejected) begin
						bad++;
						if (bad <= 10) begin
							$display("pixel result mismatch at %0t", $realtime);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_FB_WIDTH) fb_w = cfg_wdata;
				else fb_h = cfg_wdata;
			end
			if (cmd_valid && !cmd_stall) begin
				rasterize_beat(cmd_t'(command), a_x, a_y, b_x, b_y, color, want);
				due_results.push_back(want);
			end
			pending    <= due_results.size();
			mismatches <= bad;
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the clipped primitive rasterizer with points, rectangle fills, lines
// and tick beats under random idle gaps and result back-pressure, across a
// range of framebuffer sizes; a checker beside the block scores every result.
// ----------------------------------------------------------------------------
module testbench;
	import cpr_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [SIZE_W-1:0]  cfg_wdata;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [1:0]         command;
	logic signed [15:0] a_x;
	logic signed [15:0] a_y;
	logic signed [15:0] b_x;
	logic signed [15:0] b_y;
	logic [COLOR_W-1:0] color;
	logic               res_valid;
	logic               res_stall;
	logic               pixel_valid;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               last;
	logic               busy_res;
	logic               rejected;
	int                 pending;
	int                 mismatches;
	int                 pixel_count;
	int                 reject_count;

	// stimulus-side view of the walk: how many more beats the running walk
	// will swallow, and the effective framebuffer size last written
	int remaining;
	int counted;
	int beats;
	int fbw;
	int fbh;
	bit calm;

	clipped_primitive_rasterizer_top #(.COORD_WIDTH(16)) DUT (.*);

	cpr_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous fixed limit: far above the slowest legal run of this stimulus.
	initial begin
		#12_000_000;
		$display("FAIL clipped_primitive_rasterizer_top");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// a coordinate near the low edge, near the high edge, or anywhere inside
	function automatic int near(int lim);
		case ($urandom_range(0, 2))
			0: return int'($urandom_range(0, 12)) - 6;
			1: return lim + int'($urandom_range(0, 12)) - 6;
			default: return (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
		endcase
	endfunction

	// Number of beats a draw consumes once accepted while idle: the clipped
	// area for a fill, the longer axis for a line, nothing otherwise.
	function automatic int walk_len(cmd_t c, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by);
		int ix, iy, jx, jy, x0, y0, x1, y1;
		ix = int'(ax);
		iy = int'(ay);
		jx = int'(bx);
		jy = int'(by);
		case (c)
			OP_FILL: begin
				x0 = (ix < 0) ? 0 : ix;
				y0 = (iy < 0) ? 0 : iy;
				x1 = (ix + jx > fbw) ? fbw : ix + jx;
				y1 = (iy + jy > fbh) ? fbh : iy + jy;
				return (x1 > x0 && y1 > y0) ? (x1 - x0) * (y1 - y0) : 0;
			end
			OP_LINE: begin
				x0 = (jx > ix) ? jx - ix : ix - jx;
				y0 = (jy > iy) ? jy - iy : iy - jy;
				return (x0 > y0) ? x0 : y0;
			end
			default: return 0;
		endcase
	endfunction

	// Send one command beat, hold it through stalls, then leave a random idle gap.
	task automatic issue(input cmd_t c, input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] bx,
			input logic signed [15:0] by, input logic [COLOR_W-1:0] col);
		int n;
		// idle ticks do nothing and are left out of the beat budget
		if (remaining > 0 || c != OP_TICK) counted++;
		if (remaining > 0) begin
			remaining--;
		end else if (c != OP_TICK) begin
			n = walk_len(c, ax, ay, bx, by);
			remaining = (n > 0) ? n - 1 : 0;
		end
		// now and then switch between gappy traffic and full-rate stretches
		if ($urandom_range(0, 79) == 0) calm = !calm;
		@(negedge clk);
		command   <= c;
		a_x       <= ax;
		a_y       <= ay;
		b_x       <= bx;
		b_y       <= by;
		color     <= col;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		beats++;
		n = calm ? 0 : gap_len();
		if (n > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Drain all results, then load both size registers back to back.
	task automatic write_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FB_WIDTH;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_index <= REG_FB_HEIGHT;
		cfg_wdata <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		fbw = (w > FB_MAX) ? FB_MAX : int'(w);
		fbh = (h > FB_MAX) ? FB_MAX : int'(h);
	endtask

	task automatic random_item();
		cmd_t               c;
		logic signed [15:0] ax, ay, bx, by;
		logic [COLOR_W-1:0] col;
		int                 pick;
		col = 24'($urandom);
		ax  = rnd16();
		ay  = rnd16();
		bx  = rnd16();
		by  = rnd16();
		if (remaining > 0) begin
			// mostly advance the walk; sometimes throw in a draw that must bounce
			c = ($urandom_range(0, 99) < 12) ? cmd_t'($urandom_range(1, 3)) : OP_TICK;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				c = OP_TICK;
			end else if (pick < 22) begin
				c = OP_POINT;
				if ($urandom_range(0, 9) < 7) begin
					ax = 16'(near(fbw));
					ay = 16'(near(fbh));
				end
			end else begin
				c    = (pick < 60) ? OP_FILL : OP_LINE;
				pick = $urandom_range(0, 99);
				if (c == OP_LINE && pick >= 80 && pick < 90) begin
					// short line far out in coordinate space
					ax = 16'(int'($urandom_range(0, 65495)) - 32768);
					ay = 16'(int'($urandom_range(0, 65495)) - 32768);
					bx = 16'(int'(ax) + int'($urandom_range(0, 40)));
					by = 16'(int'(ay) + int'($urandom_range(0, 40)));
				end else if (pick < 80 || walk_len(c, ax, ay, bx, by) > 300) begin
					ax = 16'(near(fbw));
					ay = 16'(near(fbh));
					if (c == OP_FILL) begin
						bx = 16'(int'($urandom_range(0, 14)) - 2);
						by = 16'(int'($urandom_range(0, 14)) - 2);
					end else if (pick < 8) begin
						bx = ax;
						by = ay;
					end else begin
						bx = 16'(int'(ax) + int'($urandom_range(0, 40)) - 20);
						by = 16'(int'(ay) + int'($urandom_range(0, 40)) - 20);
					end
				end
				// otherwise keep the full-range fields: they clip to a short walk
			end
		end
		issue(c, ax, ay, bx, by, col);
	endtask

	// Result back-pressure: random stall runs, none starting during calm stretches.
	initial begin : result_backpressure
		int run;
		run       = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (run > 0) run--;
			else if (!calm && $urandom_range(0, 99) < 30) run = gap_len();
			res_stall <= (run > 0);
		end
	end

	initial begin : stimulus
		int target;
		int p;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_FB_WIDTH;
		cfg_wdata = '0;
		cmd_valid = 1'b0;
		command   = OP_TICK;
		a_x       = '0;
		a_y       = '0;
		b_x       = '0;
		b_y       = '0;
		color     = '0;
		remaining = 0;
		counted   = 0;
		beats     = 0;
		calm      = 1'b0;
		fbw       = 640;
		fbh       = 480;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset size of 640 x 480.
		issue(OP_TICK, 0, 0, 0, 0, 24'h000000);             // idle tick
		issue(OP_POINT, 0, 0, 0, 0, 24'hffffff);            // top-left corner
		issue(OP_POINT, 639, 479, -1, -1, 24'h000000);      // bottom-right corner
		issue(OP_POINT, 640, 0, 0, 0, 24'h00ff00);          // just off the right
		issue(OP_POINT, -1, 479, 0, 0, 24'h0000ff);         // just off the left
		issue(OP_POINT, -32768, 32767, 32767, -32768, 24'h800001);
		// fills that clip away completely
		issue(OP_FILL, -32768, -32768, 32767, 32767, 24'h123456);
		issue(OP_FILL, 5, 5, 0, 7, 24'h654321);
		// huge fill hanging off the bottom-right corner: clips to 2 x 2
		issue(OP_FILL, 638, 478, 32767, 32767, 24'hff0000);
		// a draw while the fill is running bounces
		issue(OP_LINE, rnd16(), rnd16(), rnd16(), rnd16(), 24'h5a5a5a);
		while (remaining > 0) issue(OP_TICK, 0, 0, 0, 0, 24'h000000);
		// line whose start and end coincide
		issue(OP_LINE, 32767, -32768, 32767, -32768, 24'habcdef);
		// line crossing the top-left corner
		issue(OP_LINE, -2, -1, 2, 1, 24'h00ffff);
		while (remaining > 0) issue(OP_TICK, 0, 0, 0, 0, 24'h000000);
		// shallow line leaving through the right and top edges
		issue(OP_LINE, 637, 1, 642, -2, 24'hff00ff);
		while (remaining > 0) issue(OP_TICK, 0, 0, 0, 0, 24'h000000);
		// shrink the width to one column while a 3 x 3 fill is walking
		issue(OP_FILL, 0, 0, 3, 3, 24'h0f0f0f);
		issue(OP_TICK, 0, 0, 0, 0, 24'h000000);
		issue(OP_TICK, 0, 0, 0, 0, 24'h000000);
		write_size(13'd1, 13'd480);
		while (remaining > 0) issue(OP_TICK, 0, 0, 0, 0, 24'h000000);

		// Random phases, one framebuffer size each. A phase may end mid-walk,
		// so some size changes land while a fill or a line is running.
		for (p = 0; p < 8; p++) begin
			case (p)
				0: write_size(13'd0, 13'd480);
				1: write_size(13'd1, 13'd1);
				2: write_size(13'd4096, 13'd4096);
				3: write_size(13'd8191, 13'd1);
				4: write_size(13'd16, 13'd12);
				5: write_size(13'd640, 13'd480);
				6: write_size(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
				default: write_size(13'($urandom), 13'($urandom));
			endcase
			target = counted + 180;
			while (counted < target) random_item();
		end

		// Drop valid, wait for the last results and a little beyond.
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d command beats (%0d drawing or walking) over nine framebuffer sizes.",
			beats, counted);
		$display("Saw %0d pixel writes and %0d bounced draws; %0d mismatching result beats.",
			pixel_count, reject_count, mismatches);
		if (mismatches == 0) begin
			$display("PASS clipped_primitive_rasterizer_top");
		end else begin
			$display("FAIL clipped_primitive_rasterizer_top");
		end
		$finish;
	end

endmodule
